>>> rtl/prg_pkg.sv
// Package with the shared types, constants and helpers of the PCM resampler.
`timescale 1ns / 1ps
`default_nettype none

package prg_pkg;

	// Field and register widths.
	localparam int SAMPLE_W   = 16;
	localparam int VOLUME_W   = 8;
	localparam int RATE_W     = 18;
	localparam int FADE_W     = 12;
	localparam int TOTAL_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Phase accumulator width: holds an output rate plus one source rate.
	localparam int ACC_W = 19;

	// Shared multiply-divide unit widths.
	localparam int MAG_W  = SAMPLE_W + 1;
	localparam int MUL_W  = FADE_W;
	localparam int PROD_W = MAG_W + MUL_W;
	localparam int QUO_W  = MAG_W + 1;
	localparam int CNT_W  = $clog2(PROD_W);

	// Results per input word are bounded by the minimum rate clamp.
	localparam int MAX_RESULTS = 6;
	localparam int NRES_W      = 3;

	// Gain is given in percent.
	localparam logic [FADE_W-1:0] GAIN_DIV = 12'd100;

	// Saturation bounds of a 16-bit sample.
	localparam logic signed [QUO_W-1:0] SAT_MAX = 18'sd32767;
	localparam logic signed [QUO_W-1:0] SAT_MIN = -18'sd32768;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MONO_INPUT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_ENABLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES    = 3'd5;

	// Register reset values.
	localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 18'd44100;
	localparam logic [FADE_W-1:0] FADE_LENGTH_RST = 12'd1058;

	// Input word.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic [VOLUME_W-1:0]        volume_percent;
		logic                       start_of_pass;
	} prg_in_t;

	// Output word.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
		logic                       last;
	} prg_out_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [RATE_W-1:0]  source_rate;
		logic               mono_input;
		logic               fade_in_enable;
		logic               fade_out_enable;
		logic [FADE_W-1:0]  fade_length;
		logic [TOTAL_W-1:0] total_frames;
	} prg_cfg_t;

	// Request to the shared unit: sign(a) * (|a| * b / d), truncated toward zero.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] a;
		logic [MUL_W-1:0]           b;
		logic [FADE_W-1:0]          d;
	} prg_op_t;

	// Response of the shared unit.
	typedef struct packed {
		logic                    done;
		logic signed [QUO_W-1:0] q;
	} prg_res_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_GAIN,
		SEQ_GAIN_W,
		SEQ_CHECK,
		SEQ_POS1,
		SEQ_POS2,
		SEQ_FIN,
		SEQ_FIN_W,
		SEQ_FOUT,
		SEQ_FOUT_W,
		SEQ_EMIT,
		SEQ_DONE
	} prg_seq_state_t;

	// Shared unit states.
	typedef enum logic [1:0] {
		UNIT_IDLE,
		UNIT_MUL,
		UNIT_DIV,
		UNIT_DONE
	} prg_unit_state_t;

	// Clamp a quotient to the 16-bit sample range.
	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [QUO_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[SAMPLE_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/prg_if.sv
// Handshake interfaces for the sample, frame and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

// Input sample word channel.
interface prg_sample_if import prg_pkg::*; ();
	logic    valid;
	logic    ready;
	prg_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Output frame word channel.
interface prg_frame_if import prg_pkg::*; ();
	logic     valid;
	logic     ready;
	prg_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface prg_cfg_if import prg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/prg_muldiv.sv
// Shared multiply then divide unit: one product, then one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module prg_muldiv import prg_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire prg_op_t  op,
	output prg_res_t      res
);

	prg_unit_state_t   state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  mag_q;
	logic              neg_q;
	logic [MUL_W-1:0]  b_q;
	logic [FADE_W-1:0] d_q;
	logic [PROD_W-1:0] dq_q;
	logic [FADE_W-1:0] rem_q;

	logic [MAG_W-1:0]  a_ext;
	logic [MAG_W-1:0]  a_mag;
	logic [FADE_W:0]   trial;
	logic [FADE_W:0]   diff;
	logic              fits;
	logic [QUO_W-1:0]  q_mag;

	// Magnitude of the signed operand, one bit wider so that -32768 fits.
	assign a_ext = {op.a[SAMPLE_W-1], op.a};
	assign a_mag = op.a[SAMPLE_W-1] ? (~a_ext + MAG_W'(1)) : a_ext;

	// One restoring division step.
	assign trial = {rem_q, dq_q[PROD_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = trial >= {1'b0, d_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			UNIT_IDLE: if (start) state_d = UNIT_MUL;
			UNIT_MUL:  state_d = UNIT_DIV;
			UNIT_DIV:  if (cnt_q == '0) state_d = UNIT_DONE;
			UNIT_DONE: state_d = UNIT_IDLE;
		endcase
	end

	// Outputs: the quotient gets the sign of the operand back.
	always_comb begin
		q_mag    = {1'b0, dq_q[MAG_W-1:0]};
		res.done = (state_q == UNIT_DONE);
		res.q    = neg_q ? $signed(~q_mag + QUO_W'(1)) : $signed(q_mag);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= UNIT_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == UNIT_MUL) begin
				cnt_q <= CNT_W'(PROD_W - 1);
			end else if (state_q == UNIT_DIV) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Operand, product and remainder registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			UNIT_IDLE: begin
				if (start) begin
					mag_q <= a_mag;
					neg_q <= op.a[SAMPLE_W-1];
					b_q   <= op.b;
					d_q   <= op.d;
				end
			end
			UNIT_MUL: begin
				dq_q  <= PROD_W'(mag_q) * PROD_W'(b_q);
				rem_q <= '0;
			end
			UNIT_DIV: begin
				rem_q <= fits ? diff[FADE_W-1:0] : trial[FADE_W-1:0];
				dq_q  <= {dq_q[PROD_W-2:0], fits};
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/prg_seq.sv
// Sequencer: phase accumulation, gain and fade steps, frame position bookkeeping.
`timescale 1ns / 1ps
`default_nettype none

module prg_seq import prg_pkg::*; #(
	parameter int OUTPUT_RATE      = 44100,
	parameter int FRAME_COUNT_BITS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire prg_cfg_t cfg,
	input  wire logic     in_valid,
	input  wire prg_in_t  in_word,
	output logic          in_ready,
	input  wire logic     slot_free,
	output logic          push,
	output prg_out_t      push_word
);

	localparam int POS_W = (FRAME_COUNT_BITS > TOTAL_W) ? FRAME_COUNT_BITS : TOTAL_W;
	localparam logic [ACC_W-1:0]  OUT_RATE_A = ACC_W'(OUTPUT_RATE);
	localparam logic [RATE_W-1:0] MIN_RATE   = RATE_W'((OUTPUT_RATE + 5) / 6);

	prg_seq_state_t state_q, state_d;

	logic [RATE_W-1:0]           phase_q;
	logic [FRAME_COUNT_BITS-1:0] count_q;
	logic [ACC_W-1:0]            acc_q;
	logic [RATE_W-1:0]           rate_q;
	logic [NRES_W-1:0]           n_q;
	logic                        ch_q;
	logic signed [SAMPLE_W-1:0]  l_in_q;
	logic signed [SAMPLE_W-1:0]  r_in_q;
	logic [VOLUME_W-1:0]         vol_q;
	logic signed [SAMPLE_W-1:0]  gain_q [2];
	logic signed [SAMPLE_W-1:0]  cur_q [2];
	logic                        fi_q;
	logic                        zero_q;
	logic                        fo_base_q;
	logic                        fo_q;
	logic [POS_W-1:0]            left_q;

	logic             op_start;
	prg_op_t          op_req;
	prg_res_t         op_res;

	logic             fade_ok;
	logic             fo_ok;
	logic [POS_W-1:0] pos_w;
	logic [POS_W-1:0] tot_w;
	logic [POS_W-1:0] len_w;
	logic [ACC_W-1:0] acc_step;
	logic             emit_last;
	logic             more;
	logic             fout_skip;

	prg_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (op_start),
		.op     (op_req),
		.res    (op_res)
	);

	// Frame position compares and the end-of-word test.
	assign fade_ok   = (cfg.fade_length != '0);
	assign fo_ok     = cfg.fade_out_enable && fade_ok && (cfg.total_frames != '0);
	assign pos_w     = POS_W'(count_q);
	assign tot_w     = POS_W'(cfg.total_frames);
	assign len_w     = POS_W'(cfg.fade_length);
	assign acc_step  = acc_q + ACC_W'(rate_q);
	assign emit_last = !((acc_step < OUT_RATE_A) && (n_q != NRES_W'(MAX_RESULTS - 1)));
	assign more      = (acc_q < OUT_RATE_A) && (n_q != NRES_W'(MAX_RESULTS));
	assign fout_skip = zero_q || !fo_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE:   if (in_valid) state_d = SEQ_GAIN;
			SEQ_GAIN:   state_d = SEQ_GAIN_W;
			SEQ_GAIN_W: if (op_res.done) state_d = ch_q ? SEQ_CHECK : SEQ_GAIN;
			SEQ_CHECK:  state_d = more ? SEQ_POS1 : SEQ_DONE;
			SEQ_POS1:   state_d = SEQ_POS2;
			SEQ_POS2:   state_d = SEQ_FIN;
			SEQ_FIN:    state_d = fi_q ? SEQ_FIN_W : SEQ_FOUT;
			SEQ_FIN_W:  if (op_res.done) state_d = SEQ_FOUT;
			SEQ_FOUT: begin
				if (fout_skip) state_d = ch_q ? SEQ_EMIT : SEQ_FIN;
				else state_d = SEQ_FOUT_W;
			end
			SEQ_FOUT_W: if (op_res.done) state_d = ch_q ? SEQ_EMIT : SEQ_FIN;
			SEQ_EMIT:   if (slot_free) state_d = SEQ_CHECK;
			SEQ_DONE:   state_d = SEQ_IDLE;
		endcase
	end

	// Outputs: handshakes and requests to the shared unit.
	always_comb begin
		in_ready  = 1'b0;
		op_start  = 1'b0;
		op_req    = '0;
		push      = 1'b0;
		push_word = '{out_left: cur_q[0], out_right: cur_q[1], last: emit_last};
		unique case (state_q)
			SEQ_IDLE: in_ready = 1'b1;
			SEQ_GAIN: begin
				op_start = 1'b1;
				op_req.a = ch_q ? r_in_q : l_in_q;
				op_req.b = MUL_W'(vol_q);
				op_req.d = GAIN_DIV;
			end
			SEQ_FIN: begin
				op_start = fi_q;
				op_req.a = cur_q[ch_q];
				op_req.b = count_q[MUL_W-1:0] + MUL_W'(1);
				op_req.d = cfg.fade_length;
			end
			SEQ_FOUT: begin
				op_start = !fout_skip;
				op_req.a = cur_q[ch_q];
				op_req.b = left_q[MUL_W-1:0];
				op_req.d = cfg.fade_length;
			end
			SEQ_EMIT: push = slot_free;
			default: ;
		endcase
	end

	// Persistent phase, frame counter and state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			phase_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SEQ_IDLE && in_valid && in_word.start_of_pass) begin
				count_q <= '0;
			end else if (state_q == SEQ_EMIT && slot_free) begin
				count_q <= count_q + FRAME_COUNT_BITS'(1);
			end
			if (state_q == SEQ_DONE) begin
				phase_q <= (acc_q >= OUT_RATE_A) ? RATE_W'(acc_q - OUT_RATE_A) : '0;
			end
		end
	end

	// Working registers of the word in progress.
	always_ff @(posedge clk) begin
		unique case (state_q)
			SEQ_IDLE: begin
				if (in_valid) begin
					l_in_q <= in_word.left_sample;
					r_in_q <= cfg.mono_input ? in_word.left_sample : in_word.right_sample;
					vol_q  <= in_word.volume_percent;
					rate_q <= (cfg.source_rate < MIN_RATE) ? MIN_RATE : cfg.source_rate;
					acc_q  <= in_word.start_of_pass ? '0 : ACC_W'(phase_q);
					n_q    <= '0;
					ch_q   <= 1'b0;
				end
			end
			SEQ_GAIN_W: begin
				if (op_res.done) begin
					gain_q[ch_q] <= sat16(op_res.q);
					ch_q         <= !ch_q;
				end
			end
			SEQ_POS1: begin
				fi_q      <= cfg.fade_in_enable && fade_ok && (pos_w < len_w);
				zero_q    <= fo_ok && (pos_w >= tot_w);
				fo_base_q <= fo_ok && (pos_w < tot_w);
				left_q    <= tot_w - pos_w - POS_W'(1);
				cur_q[0]  <= gain_q[0];
				cur_q[1]  <= gain_q[1];
				ch_q      <= 1'b0;
			end
			SEQ_POS2: begin
				// Inside the fade-out window exactly when the frames left are below the length.
				fo_q <= fo_base_q && (left_q < len_w);
			end
			SEQ_FIN_W: begin
				if (op_res.done) cur_q[ch_q] <= op_res.q[SAMPLE_W-1:0];
			end
			SEQ_FOUT: begin
				if (zero_q) cur_q[ch_q] <= '0;
				if (fout_skip) ch_q <= !ch_q;
			end
			SEQ_FOUT_W: begin
				if (op_res.done) begin
					cur_q[ch_q] <= op_res.q[SAMPLE_W-1:0];
					ch_q        <= !ch_q;
				end
			end
			SEQ_EMIT: begin
				if (slot_free) begin
					acc_q <= acc_step;
					n_q   <= n_q + NRES_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/pcm_resample_gain_fade_core.sv
// Top level of the nearest-neighbor PCM resampler with percent gain and linear fades.
`timescale 1ns / 1ps
`default_nettype none

// One input word (a mono or stereo 16-bit frame with a volume percent) yields zero to six
// stereo output words at OUTPUT_RATE, chosen by an exact integer phase accumulator that is
// kept across words and cleared by start_of_pass. All arithmetic runs through one shared
// multiply-divide unit that for each operation takes a start, forms one product, yields
// one quotient bit per cycle over 29 bits, and then signals done. Each input word passes
// through acceptance, the two gain operations and the phase update, and each output word
// adds its check, position and emit steps; every active fade adds one operation per channel
// per output word, and an emit waits while the output register holds an untaken word. The
// input is not ready while a word is in progress. Output words pass through a one-entry
// output register, so a waiting result does not hold up the next input word.
// Configuration writes are always accepted and take effect at once.
module pcm_resample_gain_fade_core import prg_pkg::*; #(
	parameter int OUTPUT_RATE      = 44100,
	parameter int FRAME_COUNT_BITS = 32
) (
	input wire logic    clk,
	input wire logic    arst_n,
	prg_sample_if.sink  samples,
	prg_frame_if.source frames,
	prg_cfg_if.sink     cfg
);

	prg_cfg_t cfg_q;
	logic     out_valid_q;
	prg_out_t out_data_q;
	logic     slot_free;
	logic     seq_push;
	prg_out_t seq_word;
	logic     seq_ready;

	// Configuration register file.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_rate     <= SOURCE_RATE_RST;
			cfg_q.mono_input      <= 1'b0;
			cfg_q.fade_in_enable  <= 1'b0;
			cfg_q.fade_out_enable <= 1'b0;
			cfg_q.fade_length     <= FADE_LENGTH_RST;
			cfg_q.total_frames    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SOURCE_RATE:     cfg_q.source_rate <= cfg.data[RATE_W-1:0];
				REG_MONO_INPUT:      cfg_q.mono_input <= cfg.data[0];
				REG_FADE_IN_ENABLE:  cfg_q.fade_in_enable <= cfg.data[0];
				REG_FADE_OUT_ENABLE: cfg_q.fade_out_enable <= cfg.data[0];
				REG_FADE_LENGTH:     cfg_q.fade_length <= cfg.data[FADE_W-1:0];
				REG_TOTAL_FRAMES:    cfg_q.total_frames <= cfg.data[TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer with the shared arithmetic unit.
	prg_seq #(
		.OUTPUT_RATE      (OUTPUT_RATE),
		.FRAME_COUNT_BITS (FRAME_COUNT_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (samples.valid),
		.in_word   (samples.data),
		.in_ready  (seq_ready),
		.slot_free (slot_free),
		.push      (seq_push),
		.push_word (seq_word)
	);

	assign samples.ready = seq_ready;

	// Output register: the slot is free when empty or when its word leaves this cycle.
	assign slot_free    = !out_valid_q || frames.ready;
	assign frames.valid = out_valid_q;
	assign frames.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_push) begin
			out_valid_q <= 1'b1;
		end else if (frames.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_push) out_data_q <= seq_word;
	end

	// A word is never pushed over one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		seq_push |-> (!out_valid_q || frames.ready))
		else $error("output word overwritten while waiting");

	// An accepted input word keeps the input closed on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> !samples.ready)
		else $error("input reopened right after a word was accepted");

	// Results are only produced while no input word can be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		seq_push |-> !samples.ready)
		else $error("output word pushed while the input was open");

endmodule

`default_nettype wire
